/* hdl/lce_pkg.sv */
// ----------------------------------------------------------------------------
// Console line editor package
// Shared types, codes and character constants for the line editor core.
// ----------------------------------------------------------------------------
package lce_pkg;

  // Result kinds carried on the master-side tuser
  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ABORT = 2'd3;

  // Control characters
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_ETX  = 8'h03;
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_DOT  = 8'h2E;

  // Register map and reset value
  localparam int unsigned PADDR_W     = 3;
  localparam logic [5:0]  MAX_LEN_RST = 6'd32;
  localparam logic        REG_MAX_LEN = 1'b0;

  // Field widths fixed by the stream formats
  localparam int unsigned LEN_W = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ROUTE,
    ST_ECHO1,
    ST_ECHO2,
    ST_READ,
    ST_CHAR,
    ST_DONE,
    ST_ABORT
  } state_e;

  // Selects which result the datapath presents
  typedef enum logic [2:0] {
    SEL_ECHO1,
    SEL_ECHO2,
    SEL_CHAR,
    SEL_DONE,
    SEL_ABORT
  } out_sel_e;

  typedef struct packed {
    logic     load;       // capture the incoming byte
    logic     decode;     // classify byte, update store and count
    logic     rd_en;      // read the stored character at the pointer
    logic     adv_ptr;    // step the read pointer
    logic     clr_count;  // line delivered, empty it
    out_sel_e sel;
  } lce_cmd_t;

  typedef struct packed {
    logic abort;     // byte aborts the line
    logic echo;      // byte gives at least one echo
    logic echo2;     // byte gives a second echo
    logic done;      // line ends with this byte
    logic empty;     // no characters stored
    logic ptr_last;  // pointer sits on the last stored character
  } lce_sts_t;

endpackage

/* hdl/lce_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/lce_ctrl.sv */
// ----------------------------------------------------------------------------
// Line editor controller
// Sequences decode, echoes, line readout and end markers for one byte.
// ----------------------------------------------------------------------------
module lce_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  lce_pkg::lce_sts_t sts_i,
  output lce_pkg::lce_cmd_t cmd_o
);
  import lce_pkg::*;

  state_e state_q, state_d;
  state_e tail_st;

  // Where a finished line goes: straight to the marker when empty
  assign tail_st = sts_i.empty ? ST_DONE : ST_READ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: state_d = ST_ROUTE;
      ST_ROUTE: begin
        if (sts_i.abort)     state_d = ST_ABORT;
        else if (sts_i.echo) state_d = ST_ECHO1;
        else if (sts_i.done) state_d = tail_st;
        else                 state_d = ST_IDLE;
      end
      ST_ECHO1: begin
        if (m_ready_i) begin
          if (sts_i.echo2)     state_d = ST_ECHO2;
          else if (sts_i.done) state_d = tail_st;
          else                 state_d = ST_IDLE;
        end
      end
      ST_ECHO2: begin
        if (m_ready_i) state_d = sts_i.done ? tail_st : ST_IDLE;
      end
      ST_READ: state_d = ST_CHAR;
      ST_CHAR: begin
        if (m_ready_i) state_d = sts_i.ptr_last ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (m_ready_i) state_d = ST_IDLE;
      end
      ST_ABORT: begin
        if (m_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_ready_o         = 1'b0;
    m_valid_o         = 1'b0;
    cmd_o.load        = 1'b0;
    cmd_o.decode      = 1'b0;
    cmd_o.rd_en       = 1'b0;
    cmd_o.adv_ptr     = 1'b0;
    cmd_o.clr_count   = 1'b0;
    cmd_o.sel         = SEL_ECHO1;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
      end
      ST_DECODE: cmd_o.decode = 1'b1;
      ST_ROUTE:  ;
      ST_ECHO1: begin
        m_valid_o = 1'b1;
        cmd_o.sel = SEL_ECHO1;
      end
      ST_ECHO2: begin
        m_valid_o = 1'b1;
        cmd_o.sel = SEL_ECHO2;
      end
      ST_READ: cmd_o.rd_en = 1'b1;
      ST_CHAR: begin
        m_valid_o     = 1'b1;
        cmd_o.sel     = SEL_CHAR;
        cmd_o.adv_ptr = m_ready_i;
      end
      ST_DONE: begin
        m_valid_o       = 1'b1;
        cmd_o.sel       = SEL_DONE;
        cmd_o.clr_count = m_ready_i;
      end
      ST_ABORT: begin
        m_valid_o = 1'b1;
        cmd_o.sel = SEL_ABORT;
      end
      default: ;
    endcase
  end

  // Never take a byte while a result is on offer
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_ready_o && m_valid_o))
    else $error("input and output active together");

  // A decode always follows an accepted byte
  a_decode_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.decode)
    else $error("accepted byte not decoded");

  // A stored character is shown only right after its read
  a_char_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHAR && $past(state_q) != ST_CHAR) |-> $past(cmd_o.rd_en))
    else $error("character shown without read");

endmodule

/* hdl/lce_dpath.sv */
// ----------------------------------------------------------------------------
// Line editor datapath
// Byte register, classification, line store, count, read pointer, result mux.
// ----------------------------------------------------------------------------
module lce_dpath #(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lce_pkg::lce_cmd_t         cmd_i,
  output lce_pkg::lce_sts_t         sts_o,
  input  logic [7:0]                rx_data_i,
  input  logic [5:0]                max_length_i,
  output logic [1:0]                kind_o,
  output logic [7:0]                value_o,
  output logic [lce_pkg::LEN_W-1:0] line_length_o,
  output logic                      last_o
);
  import lce_pkg::*;

  localparam int unsigned AW    = $clog2(LINE_DEPTH);
  localparam int unsigned CNT_W = $clog2(LINE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LINE_DEPTH);
  localparam logic [5:0]       DEPTH_6 = 6'(LINE_DEPTH);

  logic [7:0]       byte_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ptr_q;
  logic [7:0]       echo_val_q, echo_val_d;
  logic             abort_q, echo_q, echo2_q, done_q;
  logic             abort_d, echo_d, echo2_d, done_d;
  logic             is_abort, is_bs, is_lf, is_cr, is_esc, is_other;
  logic             room, store_we;
  logic [5:0]       lim;
  logic [7:0]       rd_data;

  // Effective limit: zero acts as one, clamp to the store depth
  always_comb begin
    if (max_length_i == 6'd0)        lim = 6'd1;
    else if (max_length_i > DEPTH_6) lim = DEPTH_6;
    else                             lim = max_length_i;
  end

  // Classify the held byte
  always_comb begin
    is_abort = 1'b0;
    is_bs    = 1'b0;
    is_lf    = 1'b0;
    is_cr    = 1'b0;
    is_esc   = 1'b0;
    is_other = 1'b0;
    case (byte_q) inside
      CH_ETX, CH_EOT: is_abort = 1'b1;
      CH_BS:          is_bs    = 1'b1;
      CH_LF:          is_lf    = 1'b1;
      CH_CR:          is_cr    = 1'b1;
      CH_ESC:         is_esc   = 1'b1;
      default:        is_other = 1'b1;
    endcase
  end

  assign room     = (count_q < DEPTH_C);
  assign store_we = cmd_i.decode && is_other && room;

  // Count after this byte, echo and end-of-line decisions
  always_comb begin
    count_d = count_q;
    if (is_abort)                      count_d = '0;
    else if (is_bs && count_q != '0)   count_d = count_q - CNT_W'(1);
    else if (is_other && room)         count_d = count_q + CNT_W'(1);

    abort_d    = is_abort;
    echo_d     = (is_bs && count_q != '0) || is_lf || is_cr || is_esc ||
                 (is_other && byte_q != CH_NUL);
    echo2_d    = is_cr;
    done_d     = !is_abort && (is_cr || is_esc || (6'(count_d) >= lim));
    echo_val_d = byte_q;
    if (is_cr)       echo_val_d = CH_LF;
    else if (is_esc) echo_val_d = CH_DOT;
  end

  // Hold the byte on accept and the echo value on decode
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= rx_data_i;
    end
    if (cmd_i.decode) begin
      echo_val_q <= echo_val_d;
    end
  end

  // Count, pointer and decision flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      abort_q <= 1'b0;
      echo_q  <= 1'b0;
      echo2_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (cmd_i.decode) begin
        count_q <= count_d;
        ptr_q   <= '0;
        abort_q <= abort_d;
        echo_q  <= echo_d;
        echo2_q <= echo2_d;
        done_q  <= done_d;
      end else if (cmd_i.clr_count) begin
        count_q <= '0;
      end
      if (cmd_i.adv_ptr) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end
    end
  end

  lce_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (byte_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  assign sts_o.abort    = abort_q;
  assign sts_o.echo     = echo_q;
  assign sts_o.echo2    = echo2_q;
  assign sts_o.done     = done_q;
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.ptr_last = ((ptr_q + CNT_W'(1)) == count_q);

  // Result mux
  always_comb begin
    kind_o        = KIND_ECHO;
    value_o       = 8'h00;
    line_length_o = '0;
    last_o        = 1'b0;
    case (cmd_i.sel)
      SEL_ECHO1: begin
        value_o = echo_val_q;
        last_o  = !echo2_q && !done_q;
      end
      SEL_ECHO2: begin
        value_o = CH_CR;
        last_o  = !done_q;
      end
      SEL_CHAR: begin
        kind_o  = KIND_CHAR;
        value_o = rd_data;
      end
      SEL_DONE: begin
        kind_o        = KIND_DONE;
        line_length_o = LEN_W'(count_q);
        last_o        = 1'b1;
      end
      SEL_ABORT: begin
        kind_o = KIND_ABORT;
        last_o = 1'b1;
      end
      default: ;
    endcase
  end

  // The line never outgrows the store
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("character count beyond store depth");

  // Readout stays within the stored characters
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (ptr_q < count_q))
    else $error("read beyond stored line");

  // An abort leaves the line empty
  a_abort_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.decode && is_abort) |=> (count_q == '0))
    else $error("abort did not clear line");

endmodule

/* hdl/console_line_editor_core.sv */
// ----------------------------------------------------------------------------
// Console line editor core
// Builds a console line from received bytes with echo, then emits the line.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata: rx_data
//   m_axis    out  tvalid/tready, tlast   tdata: value, line_length; tuser: kind
//   apb       in   psel/penable/pready    max_length at address 0
//
// Each byte is decoded and routed, then gives its echoes, each stored
// character read back from the line RAM (a read state, then a show state)
// and the end marker. Output stalls hold the current result; no byte is
// taken until the last result of the previous byte has gone. Reset empties
// the line and sets max_length to 32; the line RAM needs no clearing.
// ----------------------------------------------------------------------------
module console_line_editor_core #(
  parameter int unsigned LINE_DEPTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // byte input
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] rx_data
  // result output
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // [7:0] value, [13:8] line_length
  output logic [1:0]                   m_axis_tuser,   // [1:0] kind
  output logic                         m_axis_tlast,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lce_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import lce_pkg::*;

  logic [5:0]       max_length_q;
  logic             cfg_we;
  lce_cmd_t         cmd;
  lce_sts_t         sts;
  logic [7:0]       value;
  logic [LEN_W-1:0] line_length;

  // Register write on the access cycle
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LEN_RST;
    end else if (cfg_we) begin
      max_length_q <= pwdata[5:0];
    end
  end

  // Register read
  assign prdata = (paddr[2] == REG_MAX_LEN) ? {26'd0, max_length_q} : 32'd0;

  lce_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lce_dpath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rx_data_i     (s_axis_tdata),
    .max_length_i  (max_length_q),
    .kind_o        (m_axis_tuser),
    .value_o       (value),
    .line_length_o (line_length),
    .last_o        (m_axis_tlast)
  );

  // Pack the result fields
  assign m_axis_tdata = {2'b00, line_length, value};

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Console line editor testbench
// Sends console bytes into the core and checks echo, line and marker results
// against a local line-editing predictor. Starts with a table of directed
// bytes, then runs phases of random lines under different max_length values,
// with random gaps on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import lce_pkg::*;

  localparam int          LINE_DEPTH   = 32;
  localparam int          SETTLE_CYC   = 80;    // longest byte plus margin
  localparam int          STALL_LIMIT  = 5000;  // cycles without any transfer
  localparam int          PHASE_ITEMS  = 28;
  localparam int          N_DIR        = 20;
  localparam int          N_PHASE      = 8;
  localparam int          MAX_REPORTS  = 60;
  localparam logic [2:0]  ADDR_MAX_LEN = 3'd0;
  localparam logic [2:0]  ADDR_SPARE   = 3'd4;  // no register behind it

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [5:0] len;
    logic       last;
  } console_res_t;

  // How a directed row is checked
  typedef enum logic [1:0] {ROW_SILENT, ROW_ONE, ROW_MODEL} row_check_e;

  typedef struct packed {
    logic [7:0] rx;
    row_check_e check;
    logic [1:0] kind;
    logic [7:0] value;
  } dir_row_t;

  typedef struct packed {
    logic [5:0] max_len;
    logic       tx_gaps;
    logic       rx_gaps;
    logic [9:0] hold;
  } phase_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_data
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] value, [13:8] line_length
  logic [1:0]  m_axis_tuser;   // [1:0] kind
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  logic [7:0]   line_mem [LINE_DEPTH];
  int           line_cnt;
  logic [5:0]   max_len_reg;
  console_res_t byte_results [$];
  console_res_t console_out_q [$];

  int  err_cnt;
  int  items_sent;
  int  idle_cyc;
  int  stall_left;
  int  hold_len;
  bit  tx_gaps;
  bit  rx_gaps;

  console_res_t seen;
  console_res_t want;

  dir_row_t dir_rows [N_DIR] = '{
    '{CH_ETX, ROW_ONE,    KIND_ABORT, 8'h00},  // abort straight after reset
    '{CH_BS,  ROW_SILENT, KIND_ECHO,  8'h00},  // backspace on empty line
    '{CH_LF,  ROW_ONE,    KIND_ECHO,  CH_LF},
    '{CH_EOT, ROW_ONE,    KIND_ABORT, 8'h00},
    '{8'h41,  ROW_ONE,    KIND_ECHO,  8'h41},
    '{CH_NUL, ROW_SILENT, KIND_ECHO,  8'h00},  // zero byte stored quietly
    '{8'hFF,  ROW_ONE,    KIND_ECHO,  8'hFF},
    '{CH_BS,  ROW_ONE,    KIND_ECHO,  CH_BS},
    '{CH_CR,  ROW_MODEL,  KIND_ECHO,  8'h00},
    '{CH_ESC, ROW_MODEL,  KIND_ECHO,  8'h00},  // escape on empty line
    '{8'h80,  ROW_ONE,    KIND_ECHO,  8'h80},
    '{8'h7F,  ROW_ONE,    KIND_ECHO,  8'h7F},
    '{CH_ESC, ROW_MODEL,  KIND_ECHO,  8'h00},
    '{8'h55,  ROW_ONE,    KIND_ECHO,  8'h55},
    '{CH_ETX, ROW_ONE,    KIND_ABORT, 8'h00},  // abort with characters held
    '{8'h01,  ROW_ONE,    KIND_ECHO,  8'h01},
    '{CH_LF,  ROW_ONE,    KIND_ECHO,  CH_LF},  // line feed mid-line
    '{CH_BS,  ROW_ONE,    KIND_ECHO,  CH_BS},
    '{CH_BS,  ROW_SILENT, KIND_ECHO,  8'h00},
    '{CH_CR,  ROW_MODEL,  KIND_ECHO,  8'h00}   // carriage return on empty line
  };

  phase_t phases [N_PHASE] = '{
    '{6'd1,  1'b1, 1'b1, 10'd0},
    '{6'd0,  1'b1, 1'b0, 10'd0},
    '{6'd63, 1'b0, 1'b1, 10'd0},
    '{6'd32, 1'b0, 1'b0, 10'd0},
    '{6'd2,  1'b1, 1'b1, 10'd0},   // lowers the limit under a part line
    '{6'd32, 1'b0, 1'b0, 10'd300}, // long output hold-off
    '{6'd7,  1'b1, 1'b1, 10'd0},
    '{6'd20, 1'b1, 1'b1, 10'd0}    // value replaced at random
  };

  console_line_editor_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(15, 40);
  endfunction

  function automatic int line_limit();
    int lim;
    lim = (max_len_reg == 6'd0) ? 1 : int'(max_len_reg);
    if (lim > LINE_DEPTH) begin
      lim = LINE_DEPTH;
    end
    return lim;
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [7:0] value, logic [5:0] len);
    console_res_t r;
    r.kind  = kind;
    r.value = value;
    r.len   = len;
    r.last  = 1'b0;
    byte_results.push_back(r);
  endfunction

  // Apply one console byte to the line and collect the results it causes
  function automatic void edit_console_byte(logic [7:0] b);
    bit ends;
    bit aborted;
    ends    = 1'b0;
    aborted = 1'b0;
    byte_results.delete();
    case (b) inside
      CH_ETX, CH_EOT: begin
        line_cnt = 0;
        aborted  = 1'b1;
        add_result(KIND_ABORT, 8'h00, 6'd0);
      end
      CH_BS: begin
        if (line_cnt > 0) begin
          line_cnt--;
          add_result(KIND_ECHO, CH_BS, 6'd0);
        end
      end
      CH_LF: begin
        add_result(KIND_ECHO, CH_LF, 6'd0);
      end
      CH_CR: begin
        add_result(KIND_ECHO, CH_LF, 6'd0);
        add_result(KIND_ECHO, CH_CR, 6'd0);
        ends = 1'b1;
      end
      CH_ESC: begin
        add_result(KIND_ECHO, CH_DOT, 6'd0);
        ends = 1'b1;
      end
      default: begin
        if (line_cnt < LINE_DEPTH) begin
          line_mem[line_cnt] = b;
          line_cnt++;
        end
        if (b != CH_NUL) begin
          add_result(KIND_ECHO, b, 6'd0);
        end
      end
    endcase
    // Deliver the line when it ends or reaches the limit
    if (!aborted) begin
      if (line_cnt >= line_limit()) begin
        ends = 1'b1;
      end
      if (ends) begin
        for (int i = 0; i < line_cnt; i++) begin
          add_result(KIND_CHAR, line_mem[i], 6'd0);
        end
        add_result(KIND_DONE, 8'h00, 6'(line_cnt));
        line_cnt = 0;
      end
    end
    if (byte_results.size() > 0) begin
      byte_results[byte_results.size() - 1].last = 1'b1;
    end
  endfunction

  // Offer one byte, wait for the request to be taken, then queue its results
  task automatic send_byte(logic [7:0] b, row_check_e check, logic [1:0] kind,
                           logic [7:0] value);
    int gap;
    console_res_t r;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    edit_console_byte(b);
    case (check)
      ROW_MODEL: begin
        foreach (byte_results[i]) console_out_q.push_back(byte_results[i]);
      end
      ROW_ONE: begin
        r.kind  = kind;
        r.value = value;
        r.len   = 6'd0;
        r.last  = 1'b1;
        console_out_q.push_back(r);
      end
      default: ;
    endcase
    // Withdraw the request once taken so it is never offered twice
    gap = tx_gaps ? (($urandom_range(0, 1) == 0) ? 0 : pick_gap()) : 0;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'($urandom());
    if (gap > 1) begin
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Mostly ordinary characters, some editing keys and odd bytes, then usually an ending
  task automatic send_random_line();
    int len;
    int r;
    logic [7:0] b;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, LINE_DEPTH + 1)
                                      : $urandom_range(0, line_limit());
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        b = CH_BS;
      end else if (r < 12) begin
        b = CH_LF;
      end else if (r < 16) begin
        b = CH_NUL;
      end else if (r < 28) begin
        b = 8'($urandom_range(0, 255));
      end else begin
        b = 8'($urandom_range(8'h20, 8'h7E));
      end
      send_byte(b, ROW_MODEL, KIND_ECHO, 8'h00);
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_byte(CH_CR, ROW_MODEL, KIND_ECHO, 8'h00);
    end else if (r < 70) begin
      send_byte(CH_ESC, ROW_MODEL, KIND_ECHO, 8'h00);
    end else if (r < 78) begin
      send_byte(CH_ETX, ROW_MODEL, KIND_ECHO, 8'h00);
    end else if (r < 85) begin
      send_byte(CH_EOT, ROW_MODEL, KIND_ECHO, 8'h00);
    end
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_MAX_LEN) begin
      max_len_reg = data[5:0];
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Read max_length back and compare with the predicted register
  task automatic check_max_len();
    logic [31:0] got;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_MAX_LEN;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== {26'd0, max_len_reg}) begin
      $error("max_length mismatch: expected %0d, actual %0d", max_len_reg, got);
      err_cnt++;
    end
  endtask

  // Hold until every queued result is out and the core has gone quiet
  task automatic wait_idle();
    while (console_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Output side: random hold-offs, plus the one long hold when asked
  always @(negedge clk_i) begin
    if (hold_len > 0) begin
      stall_left = hold_len;
      hold_len   = 0;
    end
    if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else begin
      m_axis_tready = 1'b1;
      if (rx_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.kind  = m_axis_tuser;
      seen.value = m_axis_tdata[7:0];
      seen.len   = m_axis_tdata[13:8];
      seen.last  = m_axis_tlast;
      if (console_out_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
          $error("unexpected result: kind %0d value 0x%02h", seen.kind, seen.value);
        end
      end else begin
        want = console_out_q.pop_front();
        if (seen != want) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            if (seen.kind != want.kind)
              $error("kind mismatch: expected %0d, actual %0d", want.kind, seen.kind);
            if (seen.value != want.value)
              $error("value mismatch: expected 0x%02h, actual 0x%02h",
                     want.value, seen.value);
            if (seen.len != want.len)
              $error("line_length mismatch: expected %0d, actual %0d",
                     want.len, seen.len);
            if (seen.last != want.last)
              $error("last mismatch: expected %0d, actual %0d", want.last, seen.last);
          end
        end
      end
    end
  end

  // Give up when nothing has moved for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_cyc = 0;
    end else begin
      idle_cyc++;
    end
    if (idle_cyc >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    phase_t ph;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = ADDR_MAX_LEN;
    pwdata        = 32'd0;
    line_cnt      = 0;
    max_len_reg   = MAX_LEN_RST;
    err_cnt       = 0;
    items_sent    = 0;
    idle_cyc      = 0;
    stall_left    = 0;
    hold_len      = 0;
    tx_gaps       = 1'b1;
    rx_gaps       = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed bytes at the reset limit
    check_max_len();
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].rx, dir_rows[i].check, dir_rows[i].kind, dir_rows[i].value);
    end

    // Random lines under a range of limits
    for (int p = 0; p < N_PHASE; p++) begin
      ph = phases[p];
      if (p == N_PHASE - 1) begin
        ph.max_len = 6'($urandom_range(3, 31));
      end
      wait_idle();
      apb_write(ADDR_MAX_LEN, {26'($urandom()), ph.max_len});
      check_max_len();
      if (p == 3) begin
        apb_write(ADDR_SPARE, $urandom());
        check_max_len();
      end
      tx_gaps  = ph.tx_gaps;
      rx_gaps  = ph.rx_gaps;
      hold_len = int'(ph.hold);
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        send_random_line();
      end
      // Leave a part line behind for the next limit where the limit allows
      repeat (3) send_byte(8'($urandom_range(8'h20, 8'h7E)), ROW_MODEL, KIND_ECHO, 8'h00);
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait_idle();
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
